FILE: rtl/vmp_pkg.sv
`default_nettype none

package vmp_pkg;

  localparam int MAX_DIM    = 256;
  localparam int ADDR_W     = $clog2(MAX_DIM);
  localparam int DIM_W      = 9;
  localparam int DATA_W     = 32;
  localparam int ACC_W      = 64;
  localparam int FRAC_BITS  = 16;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_MAC  = 1'b1
  } opcode_t;

  typedef enum logic {
    REG_NUM_ROWS = 1'b0,
    REG_NUM_COLS = 1'b1
  } reg_index_t;

  // Control that travels with one matrix word down the MAC pipeline.
  typedef struct packed {
    logic              col_end;
    logic              final_col;
    logic [ADDR_W-1:0] col;
  } mac_tag_t;

  // Last valid index for a size register: 0 acts as 1, above MAX_DIM acts as MAX_DIM.
  function automatic logic [ADDR_W-1:0] bound_m1(input logic [DIM_W-1:0] size);
    logic [DIM_W-1:0] m1;
    m1 = size - DIM_W'(1);
    if (size == '0) begin
      bound_m1 = '0;
    end else if (size > DIM_W'(MAX_DIM)) begin
      bound_m1 = ADDR_W'(MAX_DIM - 1);
    end else begin
      bound_m1 = m1[ADDR_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/vmp_mac.sv
`default_nettype none

module vmp_mac (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           valid,
  input  wire logic signed [vmp_pkg::DATA_W-1:0] matrix_word,
  input  wire logic signed [vmp_pkg::DATA_W-1:0] vector_word,
  input  wire vmp_pkg::mac_tag_t              tag,
  output logic                                done,
  output logic [vmp_pkg::ADDR_W-1:0]          column_index,
  output logic signed [vmp_pkg::DATA_W-1:0]   result,
  output logic                                last,
  output logic                                saturated
);
  import vmp_pkg::*;

  // Multiply stage.
  logic                     prod_valid;
  logic signed [ACC_W-1:0]  prod;
  mac_tag_t                 prod_tag;

  // Accumulate stage.
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_sum;
  logic signed [ACC_W-1:0]  prod_shifted;
  logic                     over_hi;
  logic                     over_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= valid;
    end
    prod     <= ACC_W'(matrix_word) * ACC_W'(vector_word);
    prod_tag <= tag;
  end

  always_comb begin
    prod_shifted = prod >>> FRAC_BITS;
    acc_sum      = acc + prod_shifted;
    // The sum fits in 32 bits only when its upper bits all copy bit 31.
    over_hi      = !acc_sum[ACC_W-1] && (acc_sum[ACC_W-2:DATA_W-1] != '0);
    over_lo      = acc_sum[ACC_W-1] && (acc_sum[ACC_W-2:DATA_W-1] != '1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      done <= 1'b0;
    end else begin
      done <= prod_valid && prod_tag.col_end;
      if (prod_valid) begin
        acc <= prod_tag.col_end ? '0 : acc_sum;
      end
    end
    if (prod_valid && prod_tag.col_end) begin
      column_index <= prod_tag.col;
      last         <= prod_tag.final_col;
      saturated    <= over_hi || over_lo;
      if (over_hi) begin
        result <= {1'b0, {(DATA_W-1){1'b1}}};
      end else if (over_lo) begin
        result <= {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        result <= acc_sum[DATA_W-1:0];
      end
    end
  end

  a_done_follows_word: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(valid, 2) && $past(tag.col_end, 2))
    else $error("result strobe without a column-ending word two cycles earlier");

  a_sat_clamps: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |->
      (result == {1'b0, {(DATA_W-1){1'b1}}}) || (result == {1'b1, {(DATA_W-1){1'b0}}}))
    else $error("saturated result not at a 32-bit limit");

  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    done |-> (acc == '0))
    else $error("accumulator not cleared after a column");

endmodule

`default_nettype wire

FILE: rtl/vector_matrix_product_core.sv
`default_nettype none

// Channel   Signals                                   Handshake
// command   start, opcode, vec_index, value           start && !busy
// result    done, column_index, result, last,         done strobe, one cycle
//           saturated
// config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// A word is taken every cycle; busy never rises.
// A matrix word reaches the result port through the vector store read,
// the multiply register and the accumulate and saturate register.
// A vector load writes the store at the edge it is taken and gives no result.
// Reset sets num_rows and num_cols to 1 and clears the counters and sum;
// the vector store holds no reset value. The receiver cannot stall results.

module vector_matrix_product_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [0:0]                        opcode,
  input  wire logic [vmp_pkg::ADDR_W-1:0]        vec_index,
  input  wire logic signed [vmp_pkg::DATA_W-1:0] value,
  output logic                                   done,
  output logic [vmp_pkg::ADDR_W-1:0]             column_index,
  output logic signed [vmp_pkg::DATA_W-1:0]      result,
  output logic                                   last,
  output logic                                   saturated,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [0:0]                        cfg_index,
  input  wire logic [vmp_pkg::DIM_W-1:0]         cfg_data
);
  import vmp_pkg::*;

  logic [DIM_W-1:0]    num_rows;
  logic [DIM_W-1:0]    num_cols;
  logic [ADDR_W-1:0]   row_counter;
  logic [ADDR_W-1:0]   column_counter;
  logic [ADDR_W-1:0]   rows_m1;
  logic [ADDR_W-1:0]   cols_m1;

  logic                accept;
  logic                mac_accept;
  logic                load_accept;
  mac_tag_t            tag_next;

  logic [DATA_W-1:0]   vector_store [MAX_DIM];
  logic signed [DATA_W-1:0] vector_word;
  logic signed [DATA_W-1:0] matrix_word;
  logic                rd_valid;
  mac_tag_t            rd_tag;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_comb begin
    accept      = start && !busy;
    mac_accept  = accept && (opcode_t'(opcode) == OP_MAC);
    load_accept = accept && (opcode_t'(opcode) == OP_LOAD);
    rows_m1     = bound_m1(num_rows);
    cols_m1     = bound_m1(num_cols);
    // "At or beyond" keeps a column ending even after the bound shrank mid-product.
    tag_next.col_end   = row_counter >= rows_m1;
    tag_next.final_col = column_counter >= cols_m1;
    tag_next.col       = column_counter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= DIM_W'(1);
      num_cols <= DIM_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_NUM_ROWS: num_rows <= cfg_data;
        REG_NUM_COLS: num_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter    <= '0;
      column_counter <= '0;
    end else if (mac_accept) begin
      if (tag_next.col_end) begin
        row_counter    <= '0;
        column_counter <= tag_next.final_col ? '0 : column_counter + ADDR_W'(1);
      end else begin
        row_counter <= row_counter + ADDR_W'(1);
      end
    end
  end

  // Vector store: one write port for loads, one registered read for matrix words.
  always_ff @(posedge clk) begin
    if (load_accept) begin
      vector_store[vec_index] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (mac_accept) begin
      vector_word <= vector_store[row_counter];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= mac_accept;
    end
    matrix_word <= value;
    rd_tag      <= tag_next;
  end

  vmp_mac u_mac (
    .clk          (clk),
    .rst          (rst),
    .valid        (rd_valid),
    .matrix_word  (matrix_word),
    .vector_word  (vector_word),
    .tag          (rd_tag),
    .done         (done),
    .column_index (column_index),
    .result       (result),
    .last         (last),
    .saturated    (saturated)
  );

  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(mac_accept, 3))
    else $error("result without a matrix word three cycles earlier");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    (mac_accept && !tag_next.col_end) |=> (row_counter == $past(row_counter) + ADDR_W'(1)))
    else $error("row counter did not advance inside a column");

  a_load_keeps_counters: assert property (@(posedge clk) disable iff (rst)
    load_accept |=> $stable(row_counter) && $stable(column_counter))
    else $error("vector load disturbed the product counters");

endmodule

`default_nettype wire

FILE: verif/vmp_product_checker.sv
`timescale 1ns / 100ps

module vmp_product_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic [0:0]                        opcode,
  input  logic [vmp_pkg::ADDR_W-1:0]        vec_index,
  input  logic signed [vmp_pkg::DATA_W-1:0] value,
  input  logic                              done,
  input  logic [vmp_pkg::ADDR_W-1:0]        column_index,
  input  logic signed [vmp_pkg::DATA_W-1:0] result,
  input  logic                              last,
  input  logic                              saturated,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [0:0]                        cfg_index,
  input  logic [vmp_pkg::DIM_W-1:0]         cfg_data,
  output int                                mismatch_count,
  output int                                sums_outstanding
);
  import vmp_pkg::*;

  localparam logic signed [63:0] Q_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] Q_MIN = 64'shFFFF_FFFF_8000_0000;

  typedef struct packed {
    logic [ADDR_W-1:0]        col;
    logic signed [DATA_W-1:0] sum;
    logic                     fin;
    logic                     sat;
  } column_sum_t;

  logic signed [DATA_W-1:0] x_words [MAX_DIM];
  logic signed [63:0]       acc;
  int unsigned              row_pos;
  int unsigned              col_pos;
  logic [DIM_W-1:0]         rows_reg;
  logic [DIM_W-1:0]         cols_reg;
  column_sum_t              sums_due [$];
  int                       n_bad = 0;

  assign mismatch_count = n_bad;

  // A size of zero behaves as one and anything past the store depth as the full depth.
  function automatic int unsigned eff_size(logic [DIM_W-1:0] s);
    if (s == '0) return 1;
    if (s > MAX_DIM) return MAX_DIM;
    return s;
  endfunction

  task automatic report_mismatch(string msg);
    if (n_bad < 100) $display("%0t ns: %s", $time, msg);
    n_bad++;
  endtask

  task automatic accumulate_word(opcode_t op, logic [ADDR_W-1:0] idx,
                                 logic signed [DATA_W-1:0] v);
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] prod;
    column_sum_t        cs;
    if (op == OP_LOAD) begin
      x_words[idx] = v;
    end else begin
      a = v;
      b = x_words[row_pos];
      prod = a * b;
      acc = acc + (prod >>> FRAC_BITS);
      // A shrunken row count may leave the row position past the new end.
      if (row_pos + 1 < eff_size(rows_reg)) begin
        row_pos++;
      end else begin
        cs.col = ADDR_W'(col_pos);
        cs.sat = (acc > Q_MAX) || (acc < Q_MIN);
        if (acc > Q_MAX) begin
          cs.sum = 32'sh7FFF_FFFF;
        end else if (acc < Q_MIN) begin
          cs.sum = 32'sh8000_0000;
        end else begin
          cs.sum = acc[DATA_W-1:0];
        end
        cs.fin = (col_pos + 1 >= eff_size(cols_reg));
        sums_due.push_back(cs);
        acc = '0;
        row_pos = 0;
        col_pos = cs.fin ? 0 : col_pos + 1;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    column_sum_t want;
    if (rst) begin
      acc = '0;
      row_pos = 0;
      col_pos = 0;
      rows_reg = DIM_W'(1);
      cols_reg = DIM_W'(1);
      sums_due.delete();
    end else begin
      if (done) begin
        if (sums_due.size() == 0) begin
          report_mismatch($sformatf("column %0d arrived with no sum due", column_index));
        end else begin
          want = sums_due.pop_front();
          if (column_index !== want.col)
            report_mismatch($sformatf("column_index %0d, want %0d", column_index, want.col));
          if (result !== want.sum)
            report_mismatch($sformatf("column %0d: result %h, want %h",
                                      want.col, result, want.sum));
          if (last !== want.fin)
            report_mismatch($sformatf("column %0d: last %b, want %b", want.col, last, want.fin));
          if (saturated !== want.sat)
            report_mismatch($sformatf("column %0d: saturated %b, want %b",
                                      want.col, saturated, want.sat));
        end
      end
      // A word taken at the same edge as a register write still sees the old sizes.
      if (start && !busy) accumulate_word(opcode_t'(opcode), vec_index, value);
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_NUM_ROWS: rows_reg = cfg_data;
          REG_NUM_COLS: cols_reg = cfg_data;
          default: ;
        endcase
      end
    end
    sums_outstanding <= sums_due.size();
  end

endmodule

FILE: verif/vector_matrix_product_core_tb.sv
`timescale 1ns / 100ps

module vector_matrix_product_core_tb;
  import vmp_pkg::*;

  localparam int PIPE_DEPTH   = 3;
  localparam int RANDOM_WORDS = 960;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [0:0]               opcode = OP_LOAD;
  logic [ADDR_W-1:0]        vec_index = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     cfg_valid = 1'b0;
  logic [0:0]               cfg_index = REG_NUM_ROWS;
  logic [DIM_W-1:0]         cfg_data = '0;
  logic                     busy;
  logic                     done;
  logic [ADDR_W-1:0]        column_index;
  logic signed [DATA_W-1:0] result;
  logic                     last;
  logic                     saturated;
  logic                     cfg_ready;
  int                       mismatch_count;
  int                       sums_outstanding;
  int                       idle_pct = 0;
  int                       load_pct = 15;

  always #4 clk = ~clk;

  vector_matrix_product_core u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .vec_index    (vec_index),
    .value        (value),
    .done         (done),
    .column_index (column_index),
    .result       (result),
    .last         (last),
    .saturated    (saturated),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  vmp_product_checker u_check (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .opcode           (opcode),
    .vec_index        (vec_index),
    .value            (value),
    .done             (done),
    .column_index     (column_index),
    .result           (result),
    .last             (last),
    .saturated        (saturated),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .sums_outstanding (sums_outstanding)
  );

  initial begin
    #(8 * 200000);
    $display("TB_ERROR");
    $finish;
  end

  // Returns at the edge that takes the word; start stays high until the next call decides.
  task automatic send_word(opcode_t op, logic [ADDR_W-1:0] idx, logic [DATA_W-1:0] v);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    vec_index <= idx;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Waits until every column sum has come out and any partial column has left the pipeline.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sums_outstanding != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [DIM_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_size(logic [DIM_W-1:0] r, logic [DIM_W-1:0] c);
    if ($urandom_range(0, 1) == 1) begin
      write_reg(REG_NUM_COLS, c);
      write_reg(REG_NUM_ROWS, r);
    end else begin
      write_reg(REG_NUM_ROWS, r);
      write_reg(REG_NUM_COLS, c);
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly modest Q16.16 magnitudes so that sums clamp only now and then.
  function automatic logic [DATA_W-1:0] pick_q();
    logic [DATA_W-1:0] mag;
    mag = $urandom() >> $urandom_range(11, 26);
    case ($urandom_range(0, 15))
      0: pick_q = 32'h7FFF_FFFF;
      1: pick_q = 32'h8000_0000;
      2, 3: pick_q = $urandom();
      4: pick_q = '0;
      5: pick_q = '1;
      default: pick_q = ($urandom_range(0, 1) == 1) ? -mag : mag;
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_size();
    case ($urandom_range(0, 19))
      0: pick_size = '0;
      1: pick_size = DIM_W'(MAX_DIM);
      2: pick_size = DIM_W'($urandom_range(MAX_DIM + 1, (1 << DIM_W) - 1));
      3, 4: pick_size = DIM_W'($urandom_range(7, 40));
      default: pick_size = DIM_W'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic send_random_word();
    if ($urandom_range(0, 99) < load_pct) begin
      send_word(OP_LOAD, ADDR_W'($urandom()), pick_q());
    end else begin
      send_word(OP_MAC, ADDR_W'($urandom()), pick_q());
    end
  endtask

  initial begin
    int               phase;
    int               words_sent;
    int               n_words;
    logic [DIM_W-1:0] r;
    logic [DIM_W-1:0] c;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Every store entry is written before any product reads it.
    for (int i = 0; i < MAX_DIM; i++) send_word(OP_LOAD, ADDR_W'(i), pick_q());

    // Sizes are 1 x 1 out of reset, so each matrix word is a whole column.
    send_word(OP_LOAD, '0, 32'h7FFF_FFFF);
    send_word(OP_MAC, '0, 32'h7FFF_FFFF);
    send_word(OP_MAC, '0, 32'h8000_0000);
    send_word(OP_LOAD, '0, 32'h8000_0000);
    send_word(OP_MAC, '0, 32'h8000_0000);
    // A tiny negative product must round down to one least significant bit below zero.
    send_word(OP_LOAD, '0, 32'hFFFF_FFFF);
    send_word(OP_MAC, '0, 32'h0000_0001);
    send_word(OP_MAC, '0, '0);
    send_word(OP_LOAD, 8'hFF, 32'h0001_0000);
    send_word(OP_LOAD, '0, 32'h0001_0000);
    send_word(OP_MAC, 8'hFF, 32'h0001_8000);

    drain();
    set_size(DIM_W'(3), DIM_W'(2));
    send_word(OP_MAC, '0, 32'h0002_0000);
    send_word(OP_LOAD, ADDR_W'(1), 32'hFFFF_0000);
    send_word(OP_MAC, '0, 32'h0003_0000);
    send_word(OP_MAC, '0, 32'h7FFF_FFFF);
    repeat (3) send_word(OP_MAC, '0, pick_q());

    // Shrink the row count under a half-done column, then the column count
    // under a half-done product.
    drain();
    set_size(DIM_W'(4), DIM_W'(3));
    repeat (2) send_word(OP_MAC, '0, pick_q());
    drain();
    set_size(DIM_W'(2), DIM_W'(3));
    repeat (3) send_word(OP_MAC, '0, pick_q());
    drain();
    set_size(DIM_W'(2), DIM_W'(1));
    repeat (2) send_word(OP_MAC, '0, pick_q());

    words_sent = 0;
    phase = 0;
    while (words_sent < RANDOM_WORDS) begin
      drain();
      load_pct = 15;
      case (phase)
        0: begin
          // One row per column and 256 columns walks the column index through its range.
          r = '0;
          c = '1;
          n_words = 300;
          load_pct = 3;
        end
        1: begin
          r = '1;
          c = '0;
          n_words = 270;
          load_pct = 3;
        end
        default: begin
          r = pick_size();
          c = pick_size();
          n_words = $urandom_range(30, 90);
        end
      endcase
      set_size(r, c);
      repeat (n_words) begin
        if (words_sent < RANDOM_WORDS / 3) begin
          idle_pct = 34;
        end else if (words_sent < 2 * RANDOM_WORDS / 3) begin
          idle_pct = 88;
        end else begin
          idle_pct = 0;
        end
        send_random_word();
        words_sent++;
      end
      phase++;
    end

    drain();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
